// ===== rtl/oorrt_pkg.sv =====
// Shared types and codes for the out-of-order release ring tracker.
package oorrt_pkg;

  localparam int RING_DEPTH = 1024;

  localparam logic [1:0] FN_WRITE   = 2'd0;
  localparam logic [1:0] FN_FETCH   = 2'd1;
  localparam logic [1:0] FN_RELEASE = 2'd2;
  localparam logic [1:0] FN_NOP     = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  localparam logic [1:0] REG_RING_ENTRIES = 2'd0;
  localparam logic [10:0] RING_ENTRIES_RST = 11'd1024;

  typedef struct packed {
    logic [1:0]  func;
    logic [9:0]  slot;
    logic [31:0] event_size;
    logic [47:0] event_offset;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [9:0]  fetched_ref;
    logic [31:0] fetched_size;
    logic [47:0] fetched_offset;
    logic        release_valid;
    logic [9:0]  release_slot;
    logic [47:0] retired_offset;
    logic [9:0]  fill_count;
    logic [10:0] pending_releases;
  } out_item_t;

  // Classified command handed from front to back
  typedef struct packed {
    logic [1:0]  func;
    logic        in_range;
    logic [9:0]  slot;
    logic [31:0] event_size;
    logic [47:0] event_offset;
  } cmd_t;

endpackage

// ===== rtl/out_of_order_release_ring_tracker_top.sv =====
// Each item passes through the command queue to the sequencer, which loads its result
// into the output register; a stalled output holds the sequencer in its done state.
// The sequencer handles one command at a time and takes no new one until the last
// result is loaded. A two-entry command queue decouples the input side.
// Reset: synchronous; a clearing pass over every slot wipes sizes and flags, during
// which up to two items are queued and no result appears.
module out_of_order_release_ring_tracker_top
  import oorrt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_item,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_item,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [10:0] ring_entries;
  logic [10:0] ring_n;
  logic        cmd_valid;
  logic        cmd_take;
  cmd_t        cmd;

  assign pready = 1'b1;
  assign prdata = (paddr[1:0] == 2'(REG_RING_ENTRIES)) ? {21'd0, ring_entries} : '0;

  always_ff @(posedge clk) begin
    if (rst) ring_entries <= RING_ENTRIES_RST;
    else if (psel && penable && pwrite && paddr == 2'(REG_RING_ENTRIES))
      ring_entries <= pwdata[10:0];
  end

  // clamp ring size into 1..RING_DEPTH
  always_comb begin
    if (ring_entries == '0) ring_n = 11'd1;
    else if (ring_entries > 11'(RING_DEPTH)) ring_n = 11'(RING_DEPTH);
    else ring_n = ring_entries;
  end

  oorrt_front u_front (
    .clk, .rst, .in_valid, .in_stall, .in_item,
    .ring_n, .cmd_valid, .cmd_take, .cmd
  );

  oorrt_back u_back (
    .clk, .rst, .cmd_valid, .cmd_take, .cmd, .ring_n,
    .out_valid, .out_stall, .out_item
  );

endmodule

// ===== rtl/oorrt_front.sv =====
// Front end: accepts items, checks the slot range and queues commands.
module oorrt_front
  import oorrt_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_item_t in_item,
  input  logic [10:0] ring_n,
  output logic     cmd_valid,
  input  logic     cmd_take,
  output cmd_t     cmd
);

  localparam int QD = 2;

  cmd_t      q [QD];
  logic      wr_ptr;
  logic      rd_ptr;
  logic [1:0] count;
  logic      push;
  logic      pop;
  cmd_t      c_in;

  assign in_stall  = (count == 2'(QD));
  assign push      = in_valid && !in_stall;
  assign pop       = cmd_valid && cmd_take;
  assign cmd_valid = (count != 2'd0);
  assign cmd       = q[rd_ptr];

  always_comb begin
    c_in.func         = in_item.func;
    c_in.slot         = in_item.slot;
    c_in.event_size   = in_item.event_size;
    c_in.event_offset = in_item.event_offset;
    c_in.in_range     = ({1'b0, in_item.slot} < ring_n);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        q[wr_ptr] <= c_in;
        wr_ptr    <= ~wr_ptr;
      end
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

// ===== rtl/oorrt_back.sv =====
// Back end: slot store, fetch and retire sequencer, result register.
module oorrt_back
  import oorrt_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      cmd_valid,
  output logic      cmd_take,
  input  cmd_t      cmd,
  input  logic [10:0] ring_n,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  localparam int AW = 10;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_READ, S_FETCH, S_WALK, S_WALK_RD, S_DONE
  } state_t;

  state_t state;

  logic [31:0] size_mem [RING_DEPTH];
  logic [47:0] offs_mem [RING_DEPTH];
  logic        flag_mem [RING_DEPTH];
  logic [31:0] rd_size;
  logic [47:0] rd_offs;
  logic        rd_flag;

  logic [AW-1:0] rd_addr;
  logic [AW:0]   clr_ptr;
  logic          started;
  logic [AW-1:0] recv_ptr;
  logic [AW-1:0] ret_ptr;
  logic [10:0]   pending;
  logic [AW-1:0] next_slot;
  cmd_t          cur;
  out_item_t     res;
  out_item_t     fin;
  logic          load_out;
  logic [10:0]   walk_steps;

  function automatic logic [AW-1:0] adv(input logic [AW-1:0] p, input logic [10:0] n);
    return ({1'b0, p} < n - 11'd1) ? p + 1'b1 : '0;
  endfunction

  logic [9:0] fill_now;
  always_comb begin
    if (!started) fill_now = '0;
    else if (recv_ptr >= ret_ptr) fill_now = recv_ptr - ret_ptr;
    else fill_now = 10'(ring_n - 11'(ret_ptr - recv_ptr));
  end

  // final result: working fields plus counts and range status
  always_comb begin
    fin                  = res;
    fin.fill_count       = fill_now;
    fin.pending_releases = pending;
    if ((cur.func == FN_WRITE || cur.func == FN_RELEASE) && !cur.in_range)
      fin.status = ST_RANGE;
  end

  assign next_slot = started ? adv(recv_ptr, ring_n) : '0;
  assign cmd_take  = (state == S_IDLE) && cmd_valid;
  assign load_out  = (state == S_DONE) && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    rd_size <= size_mem[rd_addr];
    rd_offs <= offs_mem[rd_addr];
    rd_flag <= flag_mem[rd_addr];
  end

  // output register: hold while stalled, load when free
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (load_out) out_valid <= 1'b1;
    else if (!out_stall) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (load_out) out_item <= fin;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_ptr    <= '0;
      started    <= 1'b0;
      recv_ptr   <= '0;
      ret_ptr    <= '0;
      pending    <= '0;
      rd_addr    <= '0;
      walk_steps <= '0;
    end else begin
      case (state)
        S_CLEAR: begin
          // sweep size and flag stores after reset
          size_mem[clr_ptr[AW-1:0]] <= '0;
          flag_mem[clr_ptr[AW-1:0]] <= 1'b0;
          if (clr_ptr == 11'(RING_DEPTH - 1)) state <= S_IDLE;
          clr_ptr <= clr_ptr + 1'b1;
        end
        S_IDLE: begin
          if (cmd_valid) begin
            cur <= cmd;
            res <= '0;
            case (cmd.func)
              FN_WRITE: begin
                if (cmd.in_range) begin
                  size_mem[cmd.slot] <= cmd.event_size;
                  offs_mem[cmd.slot] <= cmd.event_offset;
                end
                state <= S_DONE;
              end
              FN_FETCH: begin
                rd_addr <= next_slot;
                state   <= S_READ;
              end
              FN_RELEASE: begin
                if (cmd.in_range) begin
                  rd_addr <= cmd.slot;
                  state   <= S_READ;
                end else begin
                  state <= S_DONE;
                end
              end
              default: state <= S_DONE;
            endcase
          end
        end
        S_READ: state <= S_FETCH;
        S_FETCH: begin
          if (cur.func == FN_FETCH) begin
            if (rd_size == '0) begin
              res.status <= ST_EMPTY;
            end else begin
              started            <= 1'b1;
              recv_ptr           <= rd_addr;
              res.fetched_ref    <= rd_addr;
              res.fetched_size   <= rd_size;
              res.fetched_offset <= rd_offs;
            end
            state <= S_DONE;
          end else begin
            // mark, then walk the retire pointer
            if (!rd_flag) begin
              flag_mem[cur.slot] <= 1'b1;
              pending <= pending + 11'd1;
            end
            rd_addr    <= ret_ptr;
            walk_steps <= '0;
            state      <= S_WALK_RD;
          end
        end
        S_WALK_RD: state <= S_WALK;
        S_WALK: begin
          if (rd_flag && walk_steps != 11'(RING_DEPTH)) begin
            flag_mem[rd_addr] <= 1'b0;
            size_mem[rd_addr] <= '0;
            offs_mem[rd_addr] <= '0;
            if (pending != '0) pending <= pending - 11'd1;
            res.release_valid  <= 1'b1;
            res.release_slot   <= rd_addr;
            res.retired_offset <= rd_offs;
            ret_ptr    <= adv(rd_addr, ring_n);
            rd_addr    <= adv(rd_addr, ring_n);
            walk_steps <= walk_steps + 11'd1;
            state      <= S_WALK_RD;
          end else begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (load_out) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/oorrt_checker.sv =====
// Port-level checker for the ring tracker, bound to the top level.
module oorrt_checker
  import oorrt_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_item
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled result changed");

  a_status: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_item.status != 2'd3)
    else $error("bad status");

  a_fetch_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.status != ST_OK |-> out_item.fetched_size == '0)
    else $error("failed fetch carries data");

  a_rel_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_item.release_valid |-> out_item.release_slot == '0)
    else $error("release slot without retire");

endmodule

bind out_of_order_release_ring_tracker_top oorrt_checker u_chk (
  .clk, .rst, .out_valid, .out_stall, .out_item
);
